// ===== src/sbcl_pkg.sv =====
// Shared types and constants for the STX/ETX command link.
// Used by every module of the block; no dependencies of its own.
package sbcl_pkg;

  // Sizing
  localparam int FRAME_BYTES_DEFAULT = 1024;
  localparam int MAX_RESULTS         = 5;
  localparam int QUEUE_DEPTH         = 4;
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  // Input item kinds
  localparam logic [1:0] KIND_HOST = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_TX     = 2'd0;
  localparam logic [1:0] RES_RX     = 2'd1;
  localparam logic [1:0] RES_STATUS = 2'd2;

  // Completion status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_SHORT        = 4'd1;
  localparam logic [3:0] ST_ACK_TIMEOUT  = 4'd2;
  localparam logic [3:0] ST_NAK          = 4'd3;
  localparam logic [3:0] ST_BAD_ACK      = 4'd4;
  localparam logic [3:0] ST_HEAD_TIMEOUT = 4'd5;
  localparam logic [3:0] ST_BAD_HEADER   = 4'd6;
  localparam logic [3:0] ST_DATA_TIMEOUT = 4'd7;
  localparam logic [3:0] ST_TOO_LONG     = 4'd8;

  // Line control bytes
  localparam logic [7:0] BYTE_STX = 8'hF2;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEND,
    PH_ACK,
    PH_HEAD,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] device_address;
    logic [9:0] tx_length;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic [9:0] reply_length;
    logic       last;
  } out_t;

  // All results caused by one input item, oldest in slot 0
  typedef struct packed {
    logic [2:0]                   count;
    out_t [MAX_RESULTS-1:0]       slot;
  } desc_t;

endpackage

// ===== src/sbcl_front.sv =====
// Front part of the command link: accepts items, runs the protocol state
// and emits one descriptor of up to five results per item. Uses sbcl_pkg.
module sbcl_front #(
  parameter int FRAME_BYTES = sbcl_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  sbcl_pkg::in_t  item,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data,
  output logic           desc_valid,
  output sbcl_pkg::desc_t desc
);
  import sbcl_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [31:0] LEN_LIMIT = 32'(FRAME_BYTES - 6);

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic [7:0]        check, check_next;
  logic [15:0]       reply_len, reply_len_next;
  logic [1:0]        header_index, header_index_next;
  logic [31:0]       wait_count, wait_count_next;
  logic [31:0]       timeout_ticks;

  desc_t             d;
  logic [CNT_W-1:0]  rem_dec;
  logic [15:0]       rlen_full;
  logic [31:0]       wait_inc;
  logic [9:0]        rlen_report;
  logic [3:0]        tick_status;
  logic [7:0]        hdr_check;

  function automatic out_t tx_res(input logic [7:0] b);
    out_t r;
    r = '0;
    r.result_kind = RES_TX;
    r.out_byte    = b;
    return r;
  endfunction

  function automatic out_t rx_res(input logic [7:0] b);
    out_t r;
    r = '0;
    r.result_kind = RES_RX;
    r.out_byte    = b;
    return r;
  endfunction

  function automatic out_t st_res(input logic [3:0] st, input logic [9:0] rlen);
    out_t r;
    r = '0;
    r.result_kind  = RES_STATUS;
    r.status       = st;
    r.reply_length = rlen;
    return r;
  endfunction

  // Shared arithmetic
  assign rem_dec     = (remaining != '0) ? remaining - CNT_W'(1) : remaining;
  assign rlen_full   = {reply_len[15:8], item.data_byte};
  assign wait_inc    = wait_count + 32'd1;
  assign rlen_report = (reply_len > 16'd2) ? reply_len[9:0] : 10'd0;
  assign hdr_check   = BYTE_STX ^ item.device_address ^ {6'b0, item.tx_length[9:8]}
                       ^ item.tx_length[7:0] ^ item.data_byte;

  always_comb begin
    case (phase)
      PH_ACK:  tick_status = ST_ACK_TIMEOUT;
      PH_HEAD: tick_status = ST_HEAD_TIMEOUT;
      default: tick_status = ST_DATA_TIMEOUT;
    endcase
  end

  // Advance the protocol by one item and collect its results
  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    check_next        = check;
    reply_len_next    = reply_len;
    header_index_next = header_index;
    wait_count_next   = wait_count;
    d                 = '0;
    if (accept) begin
      case (item.kind)
        KIND_HOST: begin
          if (phase == PH_IDLE) begin
            if (item.tx_length < 10'd2) begin
              d.slot[0] = st_res(ST_SHORT, 10'd0);
              d.count   = 3'd1;
              wait_count_next = '0;
            end else if ({22'b0, item.tx_length} > LEN_LIMIT) begin
              d.slot[0] = st_res(ST_TOO_LONG, 10'd0);
              d.count   = 3'd1;
              wait_count_next = '0;
            end else begin
              d.slot[0] = tx_res(BYTE_STX);
              d.slot[1] = tx_res(item.device_address);
              d.slot[2] = tx_res({6'b0, item.tx_length[9:8]});
              d.slot[3] = tx_res(item.tx_length[7:0]);
              d.slot[4] = tx_res(item.data_byte);
              d.count   = 3'd5;
              check_next     = hdr_check;
              remaining_next = CNT_W'(item.tx_length - 10'd1);
              phase_next     = PH_SEND;
            end
          end else if (phase == PH_SEND) begin
            d.slot[0]      = tx_res(item.data_byte);
            d.count        = 3'd1;
            check_next     = check ^ item.data_byte;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              // Close the frame: ETX and the block check
              check_next = check ^ item.data_byte ^ BYTE_ETX;
              d.slot[1]  = tx_res(BYTE_ETX);
              d.slot[2]  = tx_res(check ^ item.data_byte ^ BYTE_ETX);
              d.count    = 3'd3;
              phase_next = PH_ACK;
              wait_count_next = '0;
            end
          end
        end
        KIND_LINE: begin
          case (phase)
            PH_ACK: begin
              if (item.data_byte == BYTE_ACK) begin
                phase_next        = PH_HEAD;
                header_index_next = 2'd0;
                reply_len_next    = '0;
                wait_count_next   = '0;
              end else begin
                d.slot[0] = st_res((item.data_byte == BYTE_NAK) ? ST_NAK : ST_BAD_ACK,
                                   10'd0);
                d.count   = 3'd1;
                phase_next      = PH_IDLE;
                wait_count_next = '0;
              end
            end
            PH_HEAD: begin
              wait_count_next = '0;
              case (header_index)
                2'd0: begin
                  if (item.data_byte != BYTE_STX) begin
                    d.slot[0]  = st_res(ST_BAD_HEADER, 10'd0);
                    d.count    = 3'd1;
                    phase_next = PH_IDLE;
                  end else begin
                    header_index_next = 2'd1;
                  end
                end
                2'd1: header_index_next = 2'd2;
                2'd2: begin
                  reply_len_next    = {item.data_byte, 8'h00};
                  header_index_next = 2'd3;
                end
                default: begin
                  reply_len_next    = rlen_full;
                  header_index_next = 2'd0;
                  if ({16'b0, rlen_full} > LEN_LIMIT) begin
                    d.slot[0]  = st_res(ST_TOO_LONG, 10'd0);
                    d.count    = 3'd1;
                    phase_next = PH_IDLE;
                  end else begin
                    remaining_next = CNT_W'({1'b0, rlen_full} + 17'd2);
                    phase_next     = PH_DATA;
                  end
                end
              endcase
            end
            PH_DATA: begin
              wait_count_next = '0;
              remaining_next  = rem_dec;
              // Pass payload of replies over two bytes; trailer and check are dropped
              if (reply_len > 16'd2 && remaining > CNT_W'(2)) begin
                d.slot[0] = rx_res(item.data_byte);
                d.count   = 3'd1;
              end
              if (rem_dec == '0) begin
                if (d.count == 3'd1) begin
                  d.slot[1] = tx_res(BYTE_ACK);
                  d.slot[2] = st_res(ST_OK, rlen_report);
                  d.count   = 3'd3;
                end else begin
                  d.slot[0] = tx_res(BYTE_ACK);
                  d.slot[1] = st_res(ST_OK, rlen_report);
                  d.count   = 3'd2;
                end
                phase_next = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        KIND_TICK: begin
          if (phase == PH_ACK || phase == PH_HEAD || phase == PH_DATA) begin
            wait_count_next = wait_inc;
            if (wait_inc >= timeout_ticks) begin
              d.slot[0]       = st_res(tick_status, 10'd0);
              d.count         = 3'd1;
              phase_next      = PH_IDLE;
              wait_count_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
    // Mark the final result of the item
    for (int i = 0; i < MAX_RESULTS; i++) begin
      d.slot[i].last = (3'(i + 1) == d.count);
    end
  end

  assign desc_valid = accept && (d.count != 3'd0);
  assign desc       = d;

  // Protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      remaining    <= '0;
      check        <= '0;
      reply_len    <= '0;
      header_index <= '0;
      wait_count   <= '0;
    end else begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      check        <= check_next;
      reply_len    <= reply_len_next;
      header_index <= header_index_next;
      wait_count   <= wait_count_next;
    end
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  a_desc_count: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> (desc.count >= 3'd1 && desc.count <= 3'(MAX_RESULTS)))
    else $error("descriptor result count out of range");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && phase_next != PH_IDLE) |-> (accept && item.kind == KIND_HOST))
    else $error("command started without a host byte");

endmodule

// ===== src/sbcl_fifo.sv =====
// Short descriptor queue between the front and back parts.
// Uses sbcl_pkg for the descriptor type and depth.
module sbcl_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  sbcl_pkg::desc_t wr_data,
  input  logic            rd_en,
  output sbcl_pkg::desc_t rd_data,
  output logic            full,
  output logic            empty
);
  import sbcl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr, do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Store descriptors
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("descriptor written into a full queue");

endmodule

// ===== src/sbcl_back.sv =====
// Back part of the command link: unloads the head descriptor one result
// per pop. Uses sbcl_pkg for the descriptor and result types.
module sbcl_back (
  input  logic            clk,
  input  logic            rst,
  input  sbcl_pkg::desc_t head,
  input  logic            head_empty,
  output logic            head_pop,
  input  logic            pop,
  output logic            empty,
  output sbcl_pkg::out_t  result
);
  import sbcl_pkg::*;

  localparam int IDX_W = $clog2(MAX_RESULTS);

  logic [IDX_W-1:0] idx, idx_next;
  logic             take;
  logic             at_end;

  assign empty    = head_empty;
  assign result   = head.slot[idx];
  assign take     = pop && !head_empty;
  assign at_end   = (idx == IDX_W'(head.count - 3'd1));
  assign head_pop = take && at_end;

  // Step through the slots of the head descriptor
  always_comb begin
    idx_next = idx;
    if (take) begin
      idx_next = at_end ? '0 : idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  a_idx_in_desc: assert property (@(posedge clk) disable iff (rst)
    !head_empty |-> (IDX_W'(idx) < IDX_W'(head.count)))
    else $error("slot index beyond descriptor count");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    !head_empty |-> (result.last == at_end))
    else $error("last flag does not match final slot");

endmodule

// ===== src/stx_etx_bcc_command_link.sv =====
// Top level of the STX/ETX command link with XOR block check.
// Instantiates sbcl_front, sbcl_fifo and sbcl_back; uses sbcl_pkg.
//
// Usage:
//   Input channel: drive item and raise push; the item is taken at a clock
//   edge where push is high and full is low. Items are host payload bytes,
//   bytes received from the line, or time ticks.
//   Result channel: while empty is low, result holds the oldest result
//   (byte to transmit, reply byte for the host, or completion status); it
//   is taken at an edge where pop is high. last marks an item's final one.
//   Configuration: cfg_we with cfg_data writes the timeout in ticks.
// Timing:
//   An item is processed in the cycle it is taken; its descriptor is queued
//   and its first result reaches the result port once older results have
//   left. Results leave one per cycle while pop is high, up to five per
//   item. Items are taken every cycle while the four-entry descriptor queue
//   has room; an item that yields no result takes no queue entry.
// Reset: rst clears the protocol state to idle, empties the queue and sets
//   the timeout to 5000 ticks.
// Stall: when pop stays low, results wait in the queue and full rises
//   once four descriptors are held.
module stx_etx_bcc_command_link #(
  parameter int FRAME_BYTES = sbcl_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  sbcl_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output sbcl_pkg::out_t result,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data
);
  import sbcl_pkg::*;

  logic  accept;
  logic  desc_valid;
  desc_t desc;
  desc_t head;
  logic  head_empty;
  logic  head_pop;

  assign accept = push && !full;

  sbcl_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  sbcl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_valid),
    .wr_data (desc),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  sbcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the STX/ETX command link: framing, acknowledge,
// reply parsing, tick timeouts and length limits, checked result by result.
// Depends on sbcl_pkg and stx_etx_bcc_command_link from the RTL sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbcl_pkg::*;

  localparam int FRAME_LIMIT = FRAME_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {
    FLT_NONE,
    FLT_NAK,
    FLT_BAD_ACK,
    FLT_ACK_WAIT,
    FLT_BAD_HEADER,
    FLT_HEAD_WAIT,
    FLT_DATA_WAIT
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_t         item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        result;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  // Predicted link state
  phase_t      link_phase = PH_IDLE;
  logic [15:0] remain_cnt = '0;
  logic [7:0]  frame_xor = '0;
  logic [15:0] reply_len = '0;
  logic [1:0]  hdr_pos = '0;
  logic [31:0] tick_count = '0;
  logic [31:0] timeout_limit = TIMEOUT_RESET;

  out_t link_results_due[$];
  out_t want_r;

  bit   idle_on = 1'b1;
  bit   long_hold = 1'b0;
  int   pop_hold = 0;
  int   mismatches = 0;
  int   results_checked = 0;
  int   items_sent = 0;
  int   useful_items = 0;
  int   commands_opened = 0;
  int   timeout_writes = 0;
  int   cycle_count = 0;
  int   status_seen [9];

  stx_etx_bcc_command_link uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Link predictor
  // ---------------------------------------------------------------------

  function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [3:0] st,
                                     logic [9:0] rl);
    out_t r;
    r.result_kind  = k;
    r.out_byte     = b;
    r.status       = st;
    r.reply_length = rl;
    r.last         = 1'b0;
    link_results_due.push_back(r);
  endfunction

  // Return to idle and report the completion status
  function automatic void end_command(logic [3:0] st, logic [9:0] rl);
    link_phase = PH_IDLE;
    tick_count = '0;
    add_result(RES_STATUS, 8'h00, st, rl);
  endfunction

  // Transmit one frame byte and fold it into the block check
  function automatic void tx_byte(logic [7:0] b);
    frame_xor = frame_xor ^ b;
    add_result(RES_TX, b, ST_OK, 10'd0);
  endfunction

  function automatic void compute_link_results(in_t it);
    int          due_start;
    bit          taken;
    logic [15:0] span;
    logic [15:0] pos;
    out_t        tail;
    due_start = link_results_due.size();
    taken = 1'b0;
    case (it.kind)
      KIND_HOST: begin
        if (link_phase == PH_IDLE) begin
          taken = 1'b1;
          if (it.tx_length < 10'd2) begin
            end_command(ST_SHORT, 10'd0);
          end else if (int'(it.tx_length) + 6 > FRAME_LIMIT) begin
            end_command(ST_TOO_LONG, 10'd0);
          end else begin
            commands_opened++;
            frame_xor = '0;
            tx_byte(BYTE_STX);
            tx_byte(it.device_address);
            tx_byte({6'd0, it.tx_length[9:8]});
            tx_byte(it.tx_length[7:0]);
            tx_byte(it.data_byte);
            remain_cnt = {6'd0, it.tx_length} - 16'd1;
            link_phase = PH_SEND;
          end
        end else if (link_phase == PH_SEND) begin
          taken = 1'b1;
          tx_byte(it.data_byte);
          if (remain_cnt > 0) remain_cnt = remain_cnt - 16'd1;
          if (remain_cnt == 0) begin
            tx_byte(BYTE_ETX);
            add_result(RES_TX, frame_xor, ST_OK, 10'd0);
            link_phase = PH_ACK;
            tick_count = '0;
          end
        end
      end
      KIND_LINE: begin
        if (link_phase == PH_ACK) begin
          taken = 1'b1;
          if (it.data_byte == BYTE_ACK) begin
            link_phase = PH_HEAD;
            hdr_pos = '0;
            reply_len = '0;
            tick_count = '0;
          end else if (it.data_byte == BYTE_NAK) begin
            end_command(ST_NAK, 10'd0);
          end else begin
            end_command(ST_BAD_ACK, 10'd0);
          end
        end else if (link_phase == PH_HEAD) begin
          taken = 1'b1;
          tick_count = '0;
          case (hdr_pos)
            2'd0: begin
              if (it.data_byte != BYTE_STX) end_command(ST_BAD_HEADER, 10'd0);
              else hdr_pos = 2'd1;
            end
            2'd1: hdr_pos = 2'd2;
            2'd2: begin
              reply_len = {it.data_byte, 8'h00};
              hdr_pos = 2'd3;
            end
            default: begin
              reply_len = reply_len | {8'h00, it.data_byte};
              hdr_pos = '0;
              if (int'(reply_len) + 6 > FRAME_LIMIT) begin
                end_command(ST_TOO_LONG, 10'd0);
              end else begin
                remain_cnt = reply_len + 16'd2;
                link_phase = PH_DATA;
              end
            end
          endcase
        end else if (link_phase == PH_DATA) begin
          taken = 1'b1;
          tick_count = '0;
          span = reply_len + 16'd2;
          pos = span - remain_cnt;
          // Only reply payload reaches the host; trailer and check are dropped
          if (reply_len > 16'd2 && pos < reply_len)
            add_result(RES_RX, it.data_byte, ST_OK, 10'd0);
          if (remain_cnt > 0) remain_cnt = remain_cnt - 16'd1;
          if (remain_cnt == 0) begin
            add_result(RES_TX, BYTE_ACK, ST_OK, 10'd0);
            end_command(ST_OK, (reply_len > 16'd2) ? reply_len[9:0] : 10'd0);
          end
        end
      end
      KIND_TICK: begin
        if (link_phase == PH_ACK || link_phase == PH_HEAD || link_phase == PH_DATA) begin
          taken = 1'b1;
          tick_count = tick_count + 32'd1;
          if (tick_count >= timeout_limit) begin
            if (link_phase == PH_ACK) end_command(ST_ACK_TIMEOUT, 10'd0);
            else if (link_phase == PH_HEAD) end_command(ST_HEAD_TIMEOUT, 10'd0);
            else end_command(ST_DATA_TIMEOUT, 10'd0);
          end
        end
      end
      default: ;
    endcase
    if (taken) useful_items++;
    // Mark the final result of this item
    if (link_results_due.size() > due_start) begin
      tail = link_results_due.pop_back();
      tail.last = 1'b1;
      link_results_due.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH t=%0t %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    // Compare each accepted result with the oldest prediction
    if (!rst && pop && !empty) begin
      if (link_results_due.size() == 0) begin
        report_mismatch("result with nothing due", int'(result), -1);
      end else begin
        want_r = link_results_due.pop_front();
        results_checked++;
        if (result.result_kind !== want_r.result_kind)
          report_mismatch("result_kind", int'(result.result_kind),
                          int'(want_r.result_kind));
        if (result.out_byte !== want_r.out_byte)
          report_mismatch("out_byte", int'(result.out_byte), int'(want_r.out_byte));
        if (result.status !== want_r.status)
          report_mismatch("status", int'(result.status), int'(want_r.status));
        if (result.reply_length !== want_r.reply_length)
          report_mismatch("reply_length", int'(result.reply_length),
                          int'(want_r.reply_length));
        if (result.last !== want_r.last)
          report_mismatch("last", int'(result.last), int'(want_r.last));
        if (want_r.result_kind == RES_STATUS && want_r.status <= ST_TOO_LONG)
          status_seen[want_r.status]++;
      end
    end
    // Drive pop: long hold, then random stall bursts, else take every cycle
    if (long_hold) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      pop_hold <= int'($urandom_range(0, 10));
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: cycle limit reached, %0d results still due",
               link_results_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic hold_results(input int cycles);
    long_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    long_hold <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic in_t make_item(logic [1:0] k, logic [7:0] b, logic [7:0] addr,
                                    logic [9:0] len);
    in_t it;
    it.kind           = k;
    it.data_byte      = b;
    it.device_address = addr;
    it.tx_length      = len;
    return it;
  endfunction

  // Offer one item, hold it until taken, then predict its results
  task automatic send_item(input in_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    compute_link_results(it);
    items_sent++;
  endtask

  task automatic send_line(input logic [7:0] b);
    send_item(make_item(KIND_LINE, b, 8'($urandom), 10'($urandom)));
  endtask

  task automatic send_tick();
    send_item(make_item(KIND_TICK, 8'($urandom), 8'($urandom), 10'($urandom)));
  endtask

  // Send an item that the current phase ignores
  task automatic send_noise();
    in_t it;
    it = make_item(KIND_HOST, 8'($urandom), 8'($urandom), 10'($urandom));
    if ($urandom_range(0, 2) == 0)
      it.kind = KIND_SPARE;
    else if (link_phase == PH_IDLE || link_phase == PH_SEND)
      it.kind = ($urandom_range(0, 1) != 0) ? KIND_LINE : KIND_TICK;
    send_item(it);
  endtask

  // Insert a few ticks that stay short of the timeout
  task automatic maybe_ticks();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ({1'b0, tick_count} + 33'd1 < {1'b0, timeout_limit}) send_tick();
    end
  endtask

  // Stop offering items and let every due result drain
  task automatic wait_idle();
    push <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [31:0] ticks);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_limit = ticks;
    timeout_writes++;
  endtask

  // One full command: frame, acknowledge, reply header and data, with an
  // optional fault; stall_at picks where a header or data wait begins
  task automatic run_exchange(input logic [7:0] addr, input logic [9:0] tlen,
                              input logic [15:0] rlen, input fault_t fault,
                              input int stall_at);
    logic [7:0] hdr [4];
    logic [7:0] b;
    int         n;
    send_item(make_item(KIND_HOST, 8'($urandom), addr, tlen));
    while (link_phase == PH_SEND) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_item(make_item(KIND_HOST, 8'($urandom), 8'($urandom), 10'($urandom)));
    end
    if (link_phase != PH_ACK) return;

    // Acknowledge
    maybe_ticks();
    if (fault == FLT_NAK) begin
      send_line(BYTE_NAK);
      return;
    end
    if (fault == FLT_BAD_ACK) begin
      do b = 8'($urandom); while (b == BYTE_ACK || b == BYTE_NAK);
      send_line(b);
      return;
    end
    if (fault == FLT_ACK_WAIT) begin
      while (link_phase == PH_ACK) send_tick();
      return;
    end
    send_line(BYTE_ACK);

    // Reply header
    hdr[0] = BYTE_STX;
    hdr[1] = 8'($urandom);
    hdr[2] = rlen[15:8];
    hdr[3] = rlen[7:0];
    if (fault == FLT_BAD_HEADER) begin
      do hdr[0] = 8'($urandom); while (hdr[0] == BYTE_STX);
    end
    n = 0;
    while (link_phase == PH_HEAD) begin
      if (fault == FLT_HEAD_WAIT && n >= stall_at) begin
        send_tick();
      end else begin
        maybe_ticks();
        if ($urandom_range(0, 9) == 0) send_noise();
        send_line(hdr[n]);
        n++;
      end
    end

    // Reply data, trailer and check
    n = 0;
    while (link_phase == PH_DATA) begin
      if (fault == FLT_DATA_WAIT && n >= stall_at) begin
        send_tick();
      end else begin
        maybe_ticks();
        if ($urandom_range(0, 9) == 0) send_noise();
        send_line(8'($urandom));
        n++;
      end
    end
  endtask

  function automatic logic [9:0] pick_tx_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 10'($urandom_range(0, 1));
    if (r == 1) return 10'($urandom_range(1019, 1023));
    if (r == 2) return 10'($urandom_range(13, 40));
    return 10'($urandom_range(2, 8));
  endfunction

  function automatic logic [15:0] pick_reply_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'($urandom_range(1019, 65535));
    if (r == 1) return 16'($urandom_range(11, 40));
    return 16'($urandom_range(0, 10));
  endfunction

  // Mostly clean exchanges; wait faults only with a short timeout
  function automatic fault_t pick_fault();
    int     r;
    fault_t f;
    r = $urandom_range(0, 19);
    if (r >= 6) return FLT_NONE;
    f = fault_t'(r + 1);
    if (timeout_limit > 32'd16 &&
        (f == FLT_ACK_WAIT || f == FLT_HEAD_WAIT || f == FLT_DATA_WAIT))
      return FLT_NONE;
    return f;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Short and oversize commands, and items that idle ignores
  task automatic test_command_rejects();
    send_item(make_item(KIND_HOST, 8'h00, 8'h00, 10'd0));
    send_item(make_item(KIND_HOST, 8'hFF, 8'hFF, 10'd1));
    send_item(make_item(KIND_HOST, 8'h55, 8'hAA, 10'd1019));
    send_item(make_item(KIND_HOST, 8'hFF, 8'hFF, 10'h3FF));
    send_item(make_item(KIND_SPARE, 8'hFF, 8'hFF, 10'h3FF));
    send_line(BYTE_ACK);
    send_tick();
  endtask

  task automatic test_ack_outcomes();
    run_exchange(8'h00, 10'd2, 16'd0, FLT_NONE, 0);
    run_exchange(8'hFF, 10'd2, 16'd0, FLT_NAK, 0);
    run_exchange(8'h5A, 10'd2, 16'd0, FLT_BAD_ACK, 0);
  endtask

  // Reply lengths around the pass-through threshold, bad and oversize headers
  task automatic test_reply_headers();
    run_exchange(8'h11, 10'd3, 16'd1, FLT_NONE, 0);
    run_exchange(8'h12, 10'd3, 16'd2, FLT_NONE, 0);
    run_exchange(8'h13, 10'd3, 16'd3, FLT_NONE, 0);
    run_exchange(8'h14, 10'd2, 16'd4, FLT_BAD_HEADER, 0);
    run_exchange(8'h15, 10'd2, 16'hFFFF, FLT_NONE, 0);
    run_exchange(8'h16, 10'd2, 16'd1019, FLT_NONE, 0);
  endtask

  task automatic test_timeouts();
    int i;
    set_timeout(32'd1);
    run_exchange(8'h21, 10'd3, 16'd4, FLT_ACK_WAIT, 0);
    for (i = 0; i < 4; i++) run_exchange(8'h22, 10'd2, 16'd3, FLT_HEAD_WAIT, i);
    run_exchange(8'h23, 10'd2, 16'd5, FLT_DATA_WAIT, 0);
    run_exchange(8'h24, 10'd2, 16'd5, FLT_DATA_WAIT, 6);
    set_timeout(32'hFFFF_FFFF);
    run_exchange(8'h25, 10'd4, 16'd6, FLT_NONE, 0);
    run_exchange(8'h26, 10'd2, 16'd0, FLT_NONE, 0);
    set_timeout(32'd3);
    run_exchange(8'h27, 10'd2, 16'd2, FLT_ACK_WAIT, 0);
    run_exchange(8'h28, 10'd2, 16'd7, FLT_DATA_WAIT, 4);
  endtask

  // Largest reply length that fits the frame buffer, ended by a data timeout
  task automatic test_longest_frames();
    run_exchange(8'hA5, 10'd2, 16'd1018, FLT_DATA_WAIT, 3);
  endtask

  // Hold results back while the sender keeps offering items
  task automatic test_backpressure();
    wait_idle();
    idle_on <= 1'b0;
    fork
      hold_results(400);
    join_none
    run_exchange(8'h3C, 10'd16, 16'd12, FLT_NONE, 0);
    wait_idle();
    idle_on <= 1'b1;
  endtask

  task automatic test_random_traffic();
    int     target;
    int     next_cfg;
    fault_t f;
    target = useful_items + 50;
    next_cfg = useful_items + 20;
    while (useful_items < target) begin
      // Run the tail of the traffic without idling
      if (useful_items > target - 20) idle_on <= 1'b0;
      if (useful_items >= next_cfg) begin
        set_timeout(32'($urandom_range(1, 12)));
        next_cfg = useful_items + 20;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        f = pick_fault();
        run_exchange(8'($urandom), pick_tx_length(), pick_reply_length(), f,
                     (f == FLT_HEAD_WAIT) ? $urandom_range(0, 3) : $urandom_range(0, 12));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_command_rejects();
    test_ack_outcomes();
    test_reply_headers();
    test_timeouts();
    test_longest_frames();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Summary: %0d items sent, %0d commands framed, %0d results checked",
             items_sent, commands_opened, results_checked);
    $display("%0d timeout writes; status ok/short/ackto/nak/badack/hdrto/badhdr/datato/long:",
             timeout_writes);
    $display("  %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7],
             status_seen[8]);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sbcl_pkg.sv
src/sbcl_front.sv
src/sbcl_fifo.sv
src/sbcl_back.sv
src/stx_etx_bcc_command_link.sv
sim/tb_top.sv
